FILE: rtl/base64_stream_decoder_assert.svh
// assertion macros used by the checker file
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// property checked only while out of reset
`define B64D_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define B64D_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/b64d_pkg.sv
`default_nettype none
package b64d_pkg;

  // queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // padding character
  localparam logic [7:0] PadChar = 8'h3D;

  // status codes reported on the last result
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_CHAR = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_BAD_PAD  = 3'd3,
    ST_LEFTOVER = 3'd4
  } status_e;

  // character classes
  typedef enum logic [1:0] {
    SYM_DATA = 2'd0,
    SYM_PAD  = 2'd1,
    SYM_BAD  = 2'd2
  } sym_kind_e;

  // classified character as it sits in the queue
  typedef struct packed {
    sym_kind_e   kind;
    logic [5:0]  value;
    logic        fin;
  } sym_t;

  // map one raw character to its class and 6-bit value
  function automatic sym_t classify(logic [7:0] c, logic fin);
    sym_t s;
    s.kind  = SYM_DATA;
    s.value = 6'd0;
    s.fin   = fin;
    if (c inside {[8'h41:8'h5A]}) begin
      s.value = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      s.value = 6'(c - 8'h47);
    end else if (c inside {[8'h30:8'h39]}) begin
      s.value = 6'(c + 8'h04);
    end else if (c == 8'h2B) begin
      s.value = 6'd62;
    end else if (c == 8'h2F) begin
      s.value = 6'd63;
    end else if (c == PadChar) begin
      s.kind = SYM_PAD;
    end else begin
      s.kind = SYM_BAD;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/base64_stream_decoder.sv
// Base64 (standard alphabet) stream decoder. One character is taken per
// cycle on the input channel while in_stall_o is low, end_of_text_i marking
// the final one; the 2nd, 3rd and 4th character of each group each give one
// data byte, and the final character always gives exactly one result with
// last_o set. The first error is latched, data stops, and status_o on the
// last result tells what went wrong (0 means the text was good; any other
// value means all bytes of that text are to be dropped). Sustained rate is
// one character per cycle while neither side stalls: a classifier front end
// writes a two-entry queue, and the decode back end pops one entry per cycle
// into a result register, so a character passes the queue and then the
// result register before its result is presented. While out_stall_i holds
// a result, characters fill the queue until in_stall_o rises.
`default_nettype none
module base64_stream_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_in_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       data_byte_o,
  output logic             byte_valid_o,
  output logic             last_o,
  output logic [2:0]       status_o
);

  logic             push;
  b64d_pkg::sym_t   push_sym;
  logic             pop;
  b64d_pkg::sym_t   head;
  logic             q_empty;
  logic             q_full;

  // accept and classify
  b64d_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_in_i     (char_in_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_sym_o    (push_sym)
  );

  // decoupling queue
  b64d_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_sym_i (push_sym),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  // decode and drive results
  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_empty_i    (q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_byte_o  (data_byte_o),
    .byte_valid_o (byte_valid_o),
    .last_o       (last_o),
    .status_o     (status_o)
  );

endmodule
`default_nettype wire

FILE: rtl/b64d_front.sv
`default_nettype none
module b64d_front (
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic [7:0]     char_in_i,
  input  wire logic           end_of_text_i,
  input  wire logic           q_full_i,
  output logic                push_o,
  output b64d_pkg::sym_t      push_sym_o
);

  // accept whenever the queue has room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // classify the character on the way in
  assign push_sym_o = b64d_pkg::classify(char_in_i, end_of_text_i);

endmodule
`default_nettype wire

FILE: rtl/b64d_queue.sv
`default_nettype none
module b64d_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire b64d_pkg::sym_t       push_sym_i,
  input  wire logic                 pop_i,
  output b64d_pkg::sym_t            head_o,
  output logic                      empty_o,
  output logic                      full_o
);

  b64d_pkg::sym_t                      mem_q [b64d_pkg::QueueDepth];
  logic [b64d_pkg::QPtrW-1:0]          wr_ptr_q, wr_ptr_d;
  logic [b64d_pkg::QPtrW-1:0]          rd_ptr_q, rd_ptr_d;
  logic [b64d_pkg::QCntW-1:0]          count_q, count_d;
  logic                                do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == b64d_pkg::QCntW'(b64d_pkg::QueueDepth));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == b64d_pkg::QPtrW'(b64d_pkg::QueueDepth - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == b64d_pkg::QPtrW'(b64d_pkg::QueueDepth - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_sym_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/b64d_back.sv
`default_nettype none
module b64d_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire b64d_pkg::sym_t head_i,
  input  wire logic           q_empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [7:0]          data_byte_o,
  output logic                byte_valid_o,
  output logic                last_o,
  output logic [2:0]          status_o
);

  // decode state
  logic [1:0]              pos_q, pos_d;
  logic [5:0]              prev_q, prev_d;
  logic [1:0]              pad_q, pad_d;
  b64d_pkg::status_e       err_q, err_d;

  // result register
  logic                    out_valid_q, out_valid_d;
  logic [7:0]              data_q, data_d;
  logic                    bvalid_q, bvalid_d;
  logic                    last_q, last_d;
  b64d_pkg::status_e       status_q, status_d;

  logic                    can_load;
  logic                    have;
  logic                    have_ok;
  logic [7:0]              byte_val;
  b64d_pkg::status_e       e;

  // pop when the result register is free or draining this cycle
  assign can_load = !out_valid_q || !out_stall_i;
  assign pop_o    = !q_empty_i && can_load;

  // decode one classified character
  always_comb begin
    pos_d    = pos_q;
    prev_d   = prev_q;
    pad_d    = pad_q;
    err_d    = err_q;
    have     = 1'b0;
    byte_val = 8'd0;
    e        = b64d_pkg::ST_OK;
    if (err_q == b64d_pkg::ST_OK) begin
      if (pad_q != 2'd0 && pos_q == 2'd0) begin
        e = b64d_pkg::ST_BAD_PAD;
      end else if (head_i.kind == b64d_pkg::SYM_PAD) begin
        if (pos_q < 2'd2) begin
          e = b64d_pkg::ST_BAD_PAD;
        end else if (pos_q == 2'd2) begin
          if (prev_q[3:0] != 4'd0) begin
            e = b64d_pkg::ST_LEFTOVER;
          end else begin
            pad_d = 2'd1;
          end
        end else begin
          if (pad_q == 2'd0 && prev_q[1:0] != 2'd0) begin
            e = b64d_pkg::ST_LEFTOVER;
          end else begin
            pad_d = pad_q + 2'd1;
          end
        end
      end else if (pad_q != 2'd0) begin
        e = b64d_pkg::ST_BAD_PAD;
      end else if (head_i.kind == b64d_pkg::SYM_BAD) begin
        e = b64d_pkg::ST_BAD_CHAR;
      end else begin
        case (pos_q)
          2'd1: begin
            byte_val = {prev_q, head_i.value[5:4]};
            have     = 1'b1;
          end
          2'd2: begin
            byte_val = {prev_q[3:0], head_i.value[5:2]};
            have     = 1'b1;
          end
          2'd3: begin
            byte_val = {prev_q[1:0], head_i.value};
            have     = 1'b1;
          end
          default: begin
            have = 1'b0;
          end
        endcase
        prev_d = head_i.value;
      end
      pos_d = pos_q + 2'd1;
      // bad length outranks an error of the final character
      if (head_i.fin && pos_d != 2'd0) begin
        e = b64d_pkg::ST_BAD_LEN;
      end
      err_d = e;
    end
    have_ok = have && (err_d == b64d_pkg::ST_OK);
    // text done: back to the reset state
    if (head_i.fin) begin
      pos_d  = 2'd0;
      prev_d = 6'd0;
      pad_d  = 2'd0;
      err_d  = b64d_pkg::ST_OK;
    end
  end

  // result register next values
  always_comb begin
    out_valid_d = out_valid_q;
    data_d      = data_q;
    bvalid_d    = bvalid_q;
    last_d      = last_q;
    status_d    = status_q;
    if (pop_o) begin
      out_valid_d = head_i.fin || have_ok;
      data_d      = have_ok ? byte_val : 8'd0;
      bvalid_d    = have_ok;
      last_d      = head_i.fin;
      status_d    = (head_i.fin && !have_ok) ? e : b64d_pkg::ST_OK;
      if (err_q != b64d_pkg::ST_OK) begin
        status_d = (head_i.fin) ? err_q : b64d_pkg::ST_OK;
      end
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      prev_q      <= 6'd0;
      pad_q       <= 2'd0;
      err_q       <= b64d_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        pos_q  <= pos_d;
        prev_q <= prev_d;
        pad_q  <= pad_d;
        err_q  <= err_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    data_q   <= data_d;
    bvalid_q <= bvalid_d;
    last_q   <= last_d;
    status_q <= status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign data_byte_o  = data_q;
  assign byte_valid_o = bvalid_q;
  assign last_o       = last_q;
  assign status_o     = status_q;

endmodule
`default_nettype wire

FILE: rtl/b64d_checker.sv
`default_nettype none
`include "base64_stream_decoder_assert.svh"
module b64d_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [7:0]  char_in_i,
  input wire logic        end_of_text_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  data_byte_o,
  input wire logic        byte_valid_o,
  input wire logic        last_o,
  input wire logic [2:0]  status_o
);

  // no result while in reset
  `B64D_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> out_valid_o !== 1'b1, "result during reset")

  // an error status only rides on a last result without data
  `B64D_ASSERT(a_status_on_last, clk_i, rst_ni, out_valid_o && status_o != b64d_pkg::ST_OK |-> last_o && !byte_valid_o, "status off last")

  // a result without data is always the last one and carries a zero byte
  `B64D_ASSERT(a_empty_is_last, clk_i, rst_ni, out_valid_o && !byte_valid_o |-> last_o && data_byte_o == 8'd0, "empty non-last result")

  // a stalled transfer holds its result
  `B64D_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(data_byte_o) && $stable(last_o) && $stable(status_o), "stalled result changed")

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);
`default_nettype wire

FILE: test/base64_stream_decoder_tb.sv
`default_nettype none
module base64_stream_decoder_tb;

  localparam int unsigned RandomItems = 480;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 120;

  // one result as the block presents it
  typedef struct packed {
    logic [7:0]        data;
    logic              bvalid;
    logic              last;
    b64d_pkg::status_e status;
  } byte_res_t;

  // one row of the directed table
  typedef struct packed {
    logic [7:0] c;
    logic       fin;
    logic       typed;
    byte_res_t  res;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic [7:0] char_in_i     = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       out_stall_i   = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] data_byte_o;
  logic       byte_valid_o;
  logic       last_o;
  logic [2:0] status_o;

  base64_stream_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_in_i     (char_in_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_byte_o   (data_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_o        (last_o),
    .status_o      (status_o)
  );

  // decoder state mirrored by the predictor
  logic [1:0]        group_pos;
  logic [17:0]       sextets;
  logic [1:0]        pad_seen;
  b64d_pkg::status_e latched_err;

  byte_res_t   bytes_due[$];
  dir_row_t    dir_rows[$];
  logic [7:0]  text_buf[$];

  int unsigned fail_count   = 0;
  int unsigned item_count   = 0;
  int unsigned text_count   = 0;
  int unsigned result_count = 0;
  int unsigned bad_texts    = 0;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;
  int unsigned hold_left    = 0;
  bit          hold_req     = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, bytes_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // 6-bit value of an alphabet character, bit 6 set when outside it
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return {1'b0, 6'(c - 8'h41)};
    if (c >= 8'h61 && c <= 8'h7A) return {1'b0, 6'(c - 8'h61 + 8'd26)};
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 6'(c - 8'h30 + 8'd52)};
    if (c == 8'h2B) return 7'd62;
    if (c == 8'h2F) return 7'd63;
    return 7'd64;
  endfunction

  // alphabet character for a 6-bit value
  function automatic logic [7:0] char_of(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + {2'b00, v};
    if (v < 6'd52) return 8'h61 + {2'b00, v} - 8'd26;
    if (v < 6'd62) return 8'h30 + {2'b00, v} - 8'd52;
    if (v == 6'd62) return 8'h2B;
    return 8'h2F;
  endfunction

  function automatic byte_res_t mk_res(input logic [7:0] d, input logic bv,
                                       input b64d_pkg::status_e st);
    byte_res_t r;
    r.data   = d;
    r.bvalid = bv;
    r.last   = 1'b1;
    r.status = st;
    return r;
  endfunction

  task automatic clear_decoder();
    group_pos   = 2'd0;
    sextets     = 18'd0;
    pad_seen    = 2'd0;
    latched_err = b64d_pkg::ST_OK;
  endtask

  // predict the results of one accepted character
  task automatic decode_char(input logic [7:0] c, input logic fin, input logic typed,
                             input byte_res_t tres);
    logic [1:0]        pos;
    logic [5:0]        prev;
    logic [6:0]        v;
    logic [7:0]        b;
    b64d_pkg::status_e e;
    bit                have;
    byte_res_t         r;
    have = 1'b0;
    b    = 8'h00;
    if (latched_err == b64d_pkg::ST_OK) begin
      pos  = group_pos;
      prev = sextets[5:0];
      e    = b64d_pkg::ST_OK;
      if (pad_seen != 2'd0 && pos == 2'd0) begin
        e = b64d_pkg::ST_BAD_PAD;
      end else if (c == b64d_pkg::PadChar) begin
        if (pos < 2'd2) begin
          e = b64d_pkg::ST_BAD_PAD;
        end else if (pos == 2'd2) begin
          if (prev[3:0] != 4'd0) e = b64d_pkg::ST_LEFTOVER;
          else pad_seen = 2'd1;
        end else begin
          if (pad_seen == 2'd0 && prev[1:0] != 2'd0) e = b64d_pkg::ST_LEFTOVER;
          else pad_seen = pad_seen + 2'd1;
        end
      end else if (pad_seen != 2'd0) begin
        e = b64d_pkg::ST_BAD_PAD;
      end else begin
        v = sextet_of(c);
        if (v[6]) begin
          e = b64d_pkg::ST_BAD_CHAR;
        end else begin
          case (pos)
            2'd1: b = {prev, v[5:4]};
            2'd2: b = {prev[3:0], v[5:2]};
            2'd3: b = {prev[1:0], v[5:0]};
            default: b = 8'h00;
          endcase
          have    = (pos != 2'd0);
          sextets = {sextets[11:0], v[5:0]};
        end
      end
      group_pos = pos + 2'd1;
      if (fin && group_pos != 2'd0) e = b64d_pkg::ST_BAD_LEN;
      latched_err = e;
    end
    if (latched_err != b64d_pkg::ST_OK) have = 1'b0;
    if (fin) begin
      r.data   = have ? b : 8'h00;
      r.bvalid = have;
      r.last   = 1'b1;
      r.status = have ? b64d_pkg::ST_OK : latched_err;
      bytes_due = {bytes_due, (typed ? tres : r)};
      clear_decoder();
    end else if (have) begin
      r.data   = b;
      r.bvalid = 1'b1;
      r.last   = 1'b0;
      r.status = b64d_pkg::ST_OK;
      bytes_due = {bytes_due, r};
    end
  endtask

  // offer one character, idling between bursts, and wait for its transfer
  task automatic send_item(input logic [7:0] c, input logic fin, input logic typed,
                           input byte_res_t tres);
    if (burst_left == 0 && !hold_req && hold_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    in_valid_i    <= 1'b1;
    char_in_i     <= c;
    end_of_text_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    decode_char(c, fin, typed, tres);
    item_count++;
    if (fin) text_count++;
  endtask

  task automatic add_row(input logic [7:0] c, input logic fin, input logic typed,
                         input byte_res_t tres);
    dir_row_t row;
    row.c     = c;
    row.fin   = fin;
    row.typed = typed;
    row.res   = tres;
    dir_rows = {dir_rows, row};
  endtask

  // a whole text, the expected final result typed on its last character
  task automatic add_text(input string s, input byte_res_t tres);
    for (int i = 0; i < s.len(); i++)
      add_row(s.getc(i), i == s.len() - 1, i == s.len() - 1, tres);
  endtask

  // random well-formed text, then maybe broken on purpose
  task automatic build_text();
    int unsigned groups;
    int unsigned pads;
    int unsigned kind;
    int unsigned idx;
    logic [5:0]  v;
    text_buf.delete();
    groups = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
    repeat (groups * 4) text_buf = {text_buf, char_of(6'($urandom_range(0, 63)))};
    pads = $urandom_range(0, 2);
    repeat (4 - pads - 1) text_buf = {text_buf, char_of(6'($urandom_range(0, 63)))};
    v = 6'($urandom_range(0, 63));
    // unused low bits before padding are zero, now and then not
    if ($urandom_range(0, 7) != 0) begin
      if (pads == 1) v[1:0] = 2'b00;
      if (pads == 2) v[3:0] = 4'b0000;
    end
    text_buf = {text_buf, char_of(v)};
    repeat (pads) text_buf = {text_buf, b64d_pkg::PadChar};
    kind = $urandom_range(0, 9);
    case (kind)
      7: begin
        // more text after the final group
        repeat ($urandom_range(1, 4))
          text_buf = {text_buf, char_of(6'($urandom_range(0, 63)))};
      end
      8: begin
        // noise: any byte, pads and alphabet mixed
        text_buf.delete();
        repeat ($urandom_range(1, 9)) begin
          case ($urandom_range(0, 9))
            0, 1:    text_buf = {text_buf, b64d_pkg::PadChar};
            2, 3, 4: text_buf = {text_buf, 8'($urandom_range(0, 255))};
            default: text_buf = {text_buf, char_of(6'($urandom_range(0, 63)))};
          endcase
        end
      end
      9: begin
        // truncated, or a pad dropped somewhere inside
        idx = $urandom_range(0, text_buf.size() - 1);
        if ($urandom_range(0, 1) == 0 && text_buf.size() > 1) void'(text_buf.pop_back());
        else text_buf[idx] = b64d_pkg::PadChar;
      end
      default: ;
    endcase
  endtask

  // wait until every expected result has come
  task automatic drain();
    in_valid_i <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result side: stall pattern and checking of every transfer
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned phase      = 0;

  always @(posedge clk_i) begin
    byte_res_t exp;
    bit        stall;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_count++;
      if (last_o === 1'b1 && status_o !== b64d_pkg::ST_OK) bad_texts++;
      if (bytes_due.size() == 0) begin
        $display("%0t unexpected result: expected none, actual data=%h bv=%b last=%b st=%0d",
                 $time, data_byte_o, byte_valid_o, last_o, status_o);
        fail_count++;
      end else begin
        exp = bytes_due.pop_front();
        if (data_byte_o !== exp.data || byte_valid_o !== exp.bvalid ||
            last_o !== exp.last || status_o !== exp.status) begin
          $display("%0t mismatch: expected data=%h bv=%b last=%b st=%0d,",
                   $time, exp.data, exp.bvalid, exp.last, exp.status,
                   " actual data=%h bv=%b last=%b st=%0d",
                   data_byte_o, byte_valid_o, last_o, status_o);
          fail_count++;
        end
      end
    end
    // long hold-off on request, otherwise a changing pattern
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    phase++;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(10, 60);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      stall = 1'b1;
      hold_left--;
    end else begin
      case (stall_mode)
        1:       stall = ($urandom_range(0, 3) == 0);
        2:       stall = $urandom_range(0, 1);
        3:       stall = (phase % 3 == 0);
        default: stall = 1'b0;
      endcase
    end
    out_stall_i <= stall;
  end

  // stimulus
  initial begin
    byte_res_t none;
    none = mk_res(8'h00, 1'b0, b64d_pkg::ST_OK);
    clear_decoder();

    // directed texts: good, padded, and each error code
    add_text("TWFu", mk_res(8'h6E, 1'b1, b64d_pkg::ST_OK));
    add_text("//8=", mk_res(8'h00, 1'b0, b64d_pkg::ST_OK));
    add_text("AA=A", mk_res(8'h00, 1'b0, b64d_pkg::ST_BAD_PAD));
    add_text("A",    mk_res(8'h00, 1'b0, b64d_pkg::ST_BAD_LEN));
    add_row("A",   1'b0, 1'b0, none);
    add_row(8'h00, 1'b0, 1'b0, none);
    add_row(8'hFF, 1'b0, 1'b0, none);
    add_row("D",   1'b1, 1'b1, mk_res(8'h00, 1'b0, b64d_pkg::ST_BAD_CHAR));
    add_text("AB==", mk_res(8'h00, 1'b0, b64d_pkg::ST_LEFTOVER));
    add_text("AAB=", mk_res(8'h00, 1'b0, b64d_pkg::ST_LEFTOVER));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].c, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].res);
    drain();

    // random texts
    while (item_count < dir_rows.size() + RandomItems) begin
      // long receiver hold-off while the sender keeps going
      if (text_count == 20 || text_count == 70) hold_req = 1'b1;
      // sender waits for everything to come back
      if (text_count % 35 == 0) drain();
      build_text();
      foreach (text_buf[i])
        send_item(text_buf[i], i == text_buf.size() - 1, 1'b0, none);
    end

    // drain and let the pipeline settle
    in_valid_i <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (bytes_due.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, bytes_due.size());
      fail_count++;
    end

    $display("covered %0d texts, %0d characters, %0d results checked", text_count,
             item_count, result_count);
    $display("%0d texts ended with an error status, %0d failures", bad_texts, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
